// ===== hw/rtl/bfpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition table package
// Shared widths, operation and status codes, and the word and token types.
// ----------------------------------------------------------------------------
package bfpt_pkg;

	localparam int MAX_PARTS = 64;
	localparam int CNT_W     = $clog2(MAX_PARTS + 1);
	localparam int SIZE_W    = 31;
	localparam int ID_W      = 16;
	localparam int SUM_W     = 37;
	localparam int PARTS_W   = 7;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;

	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND = 2'd1;
	localparam logic [OP_W-1:0] OP_USED = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SIZE_W-1:0] size_in;
		logic [ID_W-1:0]   id_in;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     found_id;
		logic [PARTS_W-1:0]  free_parts;
		logic [SUM_W-1:0]    free_bytes;
		logic [SUM_W-1:0]    total_bytes;
	} rsp_word_t;

	// Request token that walks the row of cells, one cell per cycle.
	typedef struct packed {
		logic              act;
		logic [OP_W-1:0]   op;
		logic [SIZE_W-1:0] size;
		logic [ID_W-1:0]   id;
		logic [CNT_W-1:0]  left;
		logic              have;
		logic              chg;
		logic [SIZE_W-1:0] best_size;
		logic [ID_W-1:0]   best_id;
		logic [CNT_W-1:0]  nfree;
	} tok_t;

endpackage

// ===== hw/rtl/bfpt_cell.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition table cell
// Holds one partition entry and updates the passing token for add, find and
// mark requests before handing it to the next cell.
// ----------------------------------------------------------------------------
module bfpt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bfpt_pkg::tok_t tok_in,
	output bfpt_pkg::tok_t tok_out
);
	import bfpt_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [ID_W-1:0]   id_q;
	logic              free_q;
	tok_t              tok_q;

	tok_t t;
	logic inuse;
	logic wr;
	logic nxt_free;
	logic want;

	always_comb begin
		t        = tok_in;
		wr       = 1'b0;
		nxt_free = free_q;
		want     = (tok_in.op == OP_FREE);
		inuse    = (tok_in.left != '0);
		case (tok_in.op)
			OP_ADD: begin
				if (!inuse && !tok_in.have) begin
					wr     = 1'b1;
					t.have = 1'b1;
				end
			end
			OP_FIND: begin
				if (inuse && free_q && size_q >= tok_in.size &&
				    (!tok_in.have || size_q < tok_in.best_size)) begin
					t.have      = 1'b1;
					t.best_size = size_q;
					t.best_id   = id_q;
				end
			end
			default: begin
				if (inuse && !tok_in.have && id_q == tok_in.id) begin
					t.have = 1'b1;
					if (free_q != want) begin
						nxt_free    = want;
						t.chg       = 1'b1;
						t.best_size = size_q;
					end
				end
			end
		endcase
		if ((inuse && nxt_free) || wr) begin
			t.nfree = tok_in.nfree + CNT_W'(1);
		end
		if (inuse) begin
			t.left = tok_in.left - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.act) begin
			if (wr) begin
				size_q <= tok_in.size;
				id_q   <= tok_in.id;
				free_q <= 1'b1;
			end else begin
				free_q <= nxt_free;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= t;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/best_fit_partition_table.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition table
// Fixed-partition best-fit allocator built as a row of entry cells.
// ----------------------------------------------------------------------------
// Each request word launches a token that passes through all 64 entry cells,
// one cell per clock. The token is registered at the head, in each cell and
// in the response register, which then flags the response word valid. The
// block takes one request at a time and holds req stalled until the response
// word has been taken.
module best_fit_partition_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bfpt_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bfpt_pkg::rsp_word_t rsp
);
	import bfpt_pkg::*;

	tok_t             tok [MAX_PARTS+1];
	tok_t             head_q;
	logic             busy_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_total_q;
	logic [SUM_W-1:0] sum_free_q;

	logic             accept;
	tok_t             fin;
	logic [SUM_W-1:0] nxt_total;
	logic [SUM_W-1:0] nxt_free;
	logic [CNT_W-1:0] nxt_count;
	logic [STATUS_W-1:0] nxt_status;
	logic [ID_W-1:0]  nxt_found;

	assign req_stall = busy_q | rsp_valid_q;
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign tok[0] = head_q;

	for (genvar i = 0; i < MAX_PARTS; i++) begin : g_cell
		bfpt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign fin = tok[MAX_PARTS];

	always_comb begin
		nxt_total  = sum_total_q;
		nxt_free   = sum_free_q;
		nxt_count  = count_q;
		nxt_status = fin.have ? ST_OK : ST_MISS;
		nxt_found  = '0;
		case (fin.op)
			OP_ADD: begin
				if (fin.have) begin
					nxt_total = sum_total_q + SUM_W'(fin.size);
					nxt_free  = sum_free_q + SUM_W'(fin.size);
					nxt_count = count_q + CNT_W'(1);
				end else begin
					nxt_status = ST_FULL;
				end
			end
			OP_FIND: begin
				if (fin.have) begin
					nxt_found = fin.best_id;
				end
			end
			OP_FREE: begin
				if (fin.chg) begin
					nxt_free = sum_free_q + SUM_W'(fin.best_size);
				end
			end
			default: begin
				if (fin.chg) begin
					nxt_free = sum_free_q - SUM_W'(fin.best_size);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			sum_total_q <= '0;
			sum_free_q  <= '0;
		end else begin
			head_q.act <= accept;
			if (accept) begin
				busy_q           <= 1'b1;
				head_q.op        <= req.op;
				head_q.size      <= req.size_in;
				head_q.id        <= req.id_in;
				head_q.left      <= count_q;
				head_q.have      <= 1'b0;
				head_q.chg       <= 1'b0;
				head_q.best_size <= '0;
				head_q.best_id   <= '0;
				head_q.nfree     <= '0;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (fin.act) begin
				busy_q      <= 1'b0;
				rsp_valid_q <= 1'b1;
				count_q     <= nxt_count;
				sum_total_q <= nxt_total;
				sum_free_q  <= nxt_free;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.act) begin
			rsp_q.status      <= nxt_status;
			rsp_q.found_id    <= nxt_found;
			rsp_q.free_parts  <= PARTS_W'(fin.nfree);
			rsp_q.free_bytes  <= nxt_free;
			rsp_q.total_bytes <= nxt_total;
		end
	end

endmodule
